FILE: hdl/accalu_pkg.sv
// Package for the accumulator ALU: opcode codes, flag bit positions and the
// result record that passes from the ALU datapath to the top level.
// No dependencies.
package accalu_pkg;

    localparam int unsigned DATA_W = 16;
    localparam int unsigned FLAG_W = 4;
    localparam int unsigned OP_W   = 4;

    // Flag bit positions within the NZVC nibble
    localparam int unsigned FLAG_N = 3;
    localparam int unsigned FLAG_Z = 2;
    localparam int unsigned FLAG_V = 1;
    localparam int unsigned FLAG_C = 0;

    localparam logic [DATA_W-1:0] SIGN_BIT = 16'h8000;

    typedef enum logic [OP_W-1:0] {
        OP_NOT     = 4'd0,
        OP_NEG     = 4'd1,
        OP_ASL     = 4'd2,
        OP_ASR     = 4'd3,
        OP_ROL     = 4'd4,
        OP_ROR     = 4'd5,
        OP_ADD     = 4'd6,
        OP_SUB     = 4'd7,
        OP_AND     = 4'd8,
        OP_OR      = 4'd9,
        OP_ADDNF   = 4'd10,
        OP_SUBNF   = 4'd11,
        OP_PASS    = 4'd12,
        OP_FLAGSTO = 4'd13,
        OP_TOFLA   = 4'd14
    } t_opcode;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic [FLAG_W-1:0] flags;
        logic              wr;
        logic              bad;
    } t_alu_result;

endpackage

FILE: hdl/accalu_core.sv
// Combinational ALU datapath: separate adders for add and sub, shifts, logic ops and
// NZVC flag generation. Depends on accalu_pkg.
module accalu_core
    import accalu_pkg::*;
(
    input  logic [OP_W-1:0]   i_opcode,
    input  logic [DATA_W-1:0] i_a,
    input  logic [DATA_W-1:0] i_b,
    input  logic [FLAG_W-1:0] i_flags,
    output t_alu_result       o_res
);

    logic [DATA_W:0]   sum_add;
    logic [DATA_W:0]   sum_sub;
    logic [DATA_W-1:0] r;
    logic [FLAG_W-1:0] f;

    // Share one carry form per operation: sub is a + ~b + 1
    assign sum_add = {1'b0, i_a} + {1'b0, i_b};
    assign sum_sub = {1'b0, i_a} + {1'b0, ~i_b} + {{DATA_W{1'b0}}, 1'b1};

    // Select result and update flags
    always_comb begin
        r         = i_a;
        f         = i_flags;
        o_res.wr  = 1'b1;
        o_res.bad = 1'b0;
        unique case (t_opcode'(i_opcode))
            OP_NOT: begin
                r         = ~i_a;
                f[FLAG_N] = r[DATA_W-1];
                f[FLAG_Z] = (r == '0);
            end
            OP_NEG: begin
                r         = ~i_a + {{(DATA_W-1){1'b0}}, 1'b1};
                f[FLAG_N] = r[DATA_W-1];
                f[FLAG_Z] = (r == '0);
                f[FLAG_V] = (r == SIGN_BIT);
            end
            OP_ASL: begin
                r         = {i_a[DATA_W-2:0], 1'b0};
                f[FLAG_N] = r[DATA_W-1];
                f[FLAG_Z] = (r == '0);
                f[FLAG_V] = i_a[DATA_W-1] ^ r[DATA_W-1];
                f[FLAG_C] = i_a[DATA_W-1];
            end
            OP_ASR: begin
                r         = {i_a[DATA_W-1], i_a[DATA_W-1:1]};
                f[FLAG_N] = r[DATA_W-1];
                f[FLAG_Z] = (r == '0);
                f[FLAG_C] = i_a[0];
            end
            OP_ROL: begin
                r         = {i_a[DATA_W-2:0], i_flags[FLAG_C]};
                f[FLAG_C] = i_a[DATA_W-1];
            end
            OP_ROR: begin
                r         = {i_flags[FLAG_C], i_a[DATA_W-1:1]};
                f[FLAG_C] = i_a[0];
            end
            OP_ADD: begin
                r         = sum_add[DATA_W-1:0];
                f[FLAG_N] = r[DATA_W-1];
                f[FLAG_Z] = (r == '0);
                f[FLAG_V] = ~(i_a[DATA_W-1] ^ i_b[DATA_W-1]) & (i_a[DATA_W-1] ^ r[DATA_W-1]);
                f[FLAG_C] = sum_add[DATA_W];
            end
            OP_SUB: begin
                r         = sum_sub[DATA_W-1:0];
                f[FLAG_N] = r[DATA_W-1];
                f[FLAG_Z] = (r == '0);
                f[FLAG_V] = (i_a[DATA_W-1] ^ i_b[DATA_W-1]) & (i_a[DATA_W-1] ^ r[DATA_W-1]);
                f[FLAG_C] = sum_sub[DATA_W];
            end
            OP_AND: begin
                r         = i_a & i_b;
                f[FLAG_N] = r[DATA_W-1];
                f[FLAG_Z] = (r == '0);
            end
            OP_OR: begin
                r         = i_a | i_b;
                f[FLAG_N] = r[DATA_W-1];
                f[FLAG_Z] = (r == '0);
            end
            OP_ADDNF: r = sum_add[DATA_W-1:0];
            OP_SUBNF: r = sum_sub[DATA_W-1:0];
            OP_PASS:  r = i_b;
            OP_FLAGSTO: r = {{(DATA_W-FLAG_W){1'b0}}, i_flags};
            OP_TOFLA: begin
                f        = i_a[FLAG_W-1:0];
                o_res.wr = 1'b0;
            end
            default: begin
                // Undefined opcode: keep register and flags
                o_res.wr  = 1'b0;
                o_res.bad = 1'b1;
            end
        endcase
        o_res.value = r;
        o_res.flags = f;
    end

endmodule

FILE: hdl/accumulator_alu_with_nzvc_flags.sv
// Top level of the accumulator ALU: input register, ALU datapath and result
// register. Depends on accalu_pkg and accalu_core.
//
// Usage:
//   Drive i_opcode, i_reg_value, i_operand and i_flags_in and raise start.
//   The transfer happens at the rising edge where start is high and busy is
//   low; busy is low whenever reset is released, so an operation may be
//   issued every cycle.
//   Each operation yields one result: o_result_value, o_flags_out,
//   o_writes_register and o_invalid_op, shown for exactly one cycle with
//   o_result_valid high. The operation passes through the input register,
//   then the result register around the combinational ALU datapath.
//   Throughput is one operation per clock outside reset.
//   The receiver cannot stall; it must take each result in its strobe cycle.
//   A synchronous low i_rst_n clears both valid stages and holds busy high;
//   no result is lost or invented across reset other than the items in
//   flight being dropped.
module accumulator_alu_with_nzvc_flags
    import accalu_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [OP_W-1:0]   i_opcode,
    input  logic [DATA_W-1:0] i_reg_value,
    input  logic [DATA_W-1:0] i_operand,
    input  logic [FLAG_W-1:0] i_flags_in,
    output logic              o_result_valid,
    output logic [DATA_W-1:0] o_result_value,
    output logic [FLAG_W-1:0] o_flags_out,
    output logic              o_writes_register,
    output logic              o_invalid_op
);

    logic              r_in_valid;
    logic [OP_W-1:0]   r_opcode;
    logic [DATA_W-1:0] r_reg_value;
    logic [DATA_W-1:0] r_operand;
    logic [FLAG_W-1:0] r_flags;
    logic              r_out_valid;
    t_alu_result       r_res;
    t_alu_result       n_res;
    logic              xfer_in;

    // Hold off the sender only while in reset
    assign busy    = !i_rst_n;
    assign xfer_in = start && !busy;

    // Capture the operation on every transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= xfer_in;
        end
        if (xfer_in) begin
            r_opcode    <= i_opcode;
            r_reg_value <= i_reg_value;
            r_operand   <= i_operand;
            r_flags     <= i_flags_in;
        end
    end

    accalu_core u_core (
        .i_opcode (r_opcode),
        .i_a      (r_reg_value),
        .i_b      (r_operand),
        .i_flags  (r_flags),
        .o_res    (n_res)
    );

    // Register the result for one strobe cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_in_valid;
        end
        if (r_in_valid) begin
            r_res <= n_res;
        end
    end

    assign o_result_valid    = r_out_valid;
    assign o_result_value    = r_res.value;
    assign o_flags_out       = r_res.flags;
    assign o_writes_register = r_res.wr;
    assign o_invalid_op      = r_res.bad;

    // Every transfer reaches the result strobe through the input and result registers
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        xfer_in |=> ##1 o_result_valid)
        else $error("transfer did not produce a result");

    // No strobe without an operation in flight
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(r_in_valid))
        else $error("result strobe without operation");

    // An invalid opcode never writes the register and keeps its value
    a_invalid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_invalid_op) |->
            (!o_writes_register && o_result_value == $past(r_reg_value)
             && o_flags_out == $past(r_flags)))
        else $error("invalid opcode altered state");

    // Only the flag load op skips the write besides invalid opcodes
    a_tofla_nowrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_opcode == OP_TOFLA) |=>
            (!o_writes_register && o_flags_out == $past(r_reg_value[FLAG_W-1:0])))
        else $error("flag load wrote register");

endmodule
